[rtl/core/float_power_by_squaring_top_macros.svh]
// assertion macros for the power-by-squaring controller rtl
// no dependencies; the including module provides clk and rst_n
`ifndef FLOAT_POWER_BY_SQUARING_TOP_MACROS_SVH
`define FLOAT_POWER_BY_SQUARING_TOP_MACROS_SVH

// same-cycle implication, off while in reset
`define FPBS_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define FPBS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[rtl/core/fpbs_pkg.sv]
// shared types and constants for the power-by-squaring block
// no dependencies
package fpbs_pkg;

    // binary64 field widths and internal datapath widths
    localparam int MANT_W    = 53;
    localparam int PROD_W    = 106;
    localparam int QUO_W     = 56;
    localparam int REM_W     = 54;
    localparam int EXPI_W    = 14;
    localparam int DIV_STEPS = 56;

    localparam logic [63:0] DBL_ONE  = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DBL_QNAN = 64'h7FF8_0000_0000_0000;
    localparam logic [62:0] DBL_INF  = 63'h7FF0_0000_0000_0000;

    typedef enum logic [3:0] {
        C_IDLE,
        C_WR,
        C_CHK,
        C_SQW,
        C_AK,
        C_ARD,
        C_AW,
        C_ANX,
        C_REC,
        C_RW,
        C_OUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_NORM,
        F_MUL,
        F_DIV,
        F_PREP,
        F_SHIFT,
        F_ROUND,
        F_DONE
    } fpu_state_t;

    typedef enum logic {
        FOP_MUL,
        FOP_DIV
    } fpu_op_t;

    typedef enum logic [1:0] {
        SEL_SQ,
        SEL_ACC,
        SEL_RECIP
    } opsel_t;

    typedef struct packed {
        logic   load;
        logic   wr_sq;
        logic   take_sq;
        logic   acc_init;
        logic   k_dec;
        logic   fpu_start;
        opsel_t sel;
        logic   take_acc;
        logic   out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic more_bits;
        logic bit_k;
        logic k_zero;
        logic neg;
        logic fpu_done;
    } ctrl_stat_t;

endpackage

[rtl/core/fpbs_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
module fpbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/fpbs_fpu.sv]
// multi-cycle binary64 multiply and divide unit, round to nearest even
// depends on fpbs_pkg
module fpbs_fpu (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  fpbs_pkg::fpu_op_t op,
    input  logic [63:0]       a,
    input  logic [63:0]       b,
    output logic              done,
    output logic [63:0]       res
);

    import fpbs_pkg::*;

    fpu_state_t                state_reg, state_next;
    fpu_op_t                   op_reg;
    logic                      sign_reg;
    logic [MANT_W-1:0]         ma_reg, mb_reg;
    logic signed [EXPI_W-1:0]  ea_reg, eb_reg;
    logic [5:0]                cnt_reg;
    logic [53:0]               pp_reg;
    logic [1:0]                psh_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [QUO_W-1:0]          q_reg;
    logic [PROD_W-1:0]         rp_reg;
    logic [6:0]                s_reg;
    logic [10:0]               em1_reg;
    logic                      ovf_reg;
    logic                      stin_reg;
    logic [53:0]               qv_reg;
    logic                      g_reg;
    logic                      st_reg;
    logic [63:0]               res_reg;

    logic        a_s, b_s;
    logic [10:0] a_e, b_e;
    logic [51:0] a_f, b_f;
    logic        a_zero, a_inf, a_nan, b_zero, b_inf, b_nan;
    logic        sp_hit;
    logic [63:0] sp_res;
    logic        r_sign;

    logic [26:0]       pa, pb;
    logic [53:0]       pp;
    logic [PROD_W-1:0] pp_sh;

    logic              ge;
    logic [REM_W-1:0]  diff, rem_sel;

    logic [PROD_W-1:0]        p_in;
    logic signed [EXPI_W-1:0] l_in, x_in, bn, s_full;
    logic                     stk_in;

    logic [PROD_W-1:0] gv, lowmask;
    logic [6:0]        sm1;
    logic              up;
    logic [53:0]       qr;
    logic [63:0]       enc;

    // operand fields and classes
    always_comb
    begin
        a_s    = a[63];
        a_e    = a[62:52];
        a_f    = a[51:0];
        b_s    = b[63];
        b_e    = b[62:52];
        b_f    = b[51:0];
        a_zero = (a_e == 11'd0) && (a_f == 52'd0);
        b_zero = (b_e == 11'd0) && (b_f == 52'd0);
        a_inf  = (a_e == 11'h7FF) && (a_f == 52'd0);
        b_inf  = (b_e == 11'h7FF) && (b_f == 52'd0);
        a_nan  = (a_e == 11'h7FF) && (a_f != 52'd0);
        b_nan  = (b_e == 11'h7FF) && (b_f != 52'd0);
        r_sign = a_s ^ b_s;
    end

    // zero, infinity and nan operands settle the result at once
    always_comb
    begin
        sp_hit = 1'b0;
        sp_res = DBL_QNAN;
        if (op == FOP_MUL)
        begin
            if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf))
            begin
                sp_hit = 1'b1;
                sp_res = DBL_QNAN;
            end
            else if (a_inf || b_inf)
            begin
                sp_hit = 1'b1;
                sp_res = {r_sign, DBL_INF};
            end
            else if (a_zero || b_zero)
            begin
                sp_hit = 1'b1;
                sp_res = {r_sign, 63'd0};
            end
        end
        else
        begin
            if (a_nan || b_nan || (a_zero && b_zero) || (a_inf && b_inf))
            begin
                sp_hit = 1'b1;
                sp_res = DBL_QNAN;
            end
            else if (a_inf || b_zero)
            begin
                sp_hit = 1'b1;
                sp_res = {r_sign, DBL_INF};
            end
            else if (a_zero || b_inf)
            begin
                sp_hit = 1'b1;
                sp_res = {r_sign, 63'd0};
            end
        end
    end

    // one 27x27 partial product per cycle, weight from the half selects
    always_comb
    begin
        pa = cnt_reg[1] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
        pb = cnt_reg[0] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];
        pp = pa * pb;
        case (psh_reg)
            2'd0:    pp_sh = {52'd0, pp_reg};
            2'd1:    pp_sh = {25'd0, pp_reg, 27'd0};
            default: pp_sh = {pp_reg[51:0], 54'd0};
        endcase
    end

    // restoring divide, one quotient bit per cycle
    always_comb
    begin
        ge      = rem_reg >= {1'b0, mb_reg};
        diff    = rem_reg - {1'b0, mb_reg};
        rem_sel = ge ? diff : rem_reg;
    end

    // exponent of the leading bit and right shift for the rounding point
    always_comb
    begin
        if (op_reg == FOP_MUL)
        begin
            p_in   = prod_reg;
            l_in   = prod_reg[PROD_W-1] ? 14'sd105 : 14'sd104;
            x_in   = ea_reg + eb_reg - 14'sd2150;
            stk_in = 1'b0;
        end
        else
        begin
            p_in   = {50'd0, q_reg};
            l_in   = q_reg[QUO_W-1] ? 14'sd55 : 14'sd54;
            x_in   = ea_reg - eb_reg - 14'sd55;
            stk_in = rem_reg != '0;
        end
        bn     = l_in + x_in + 14'sd1023;
        s_full = (bn >= 14'sd1) ? (l_in - 14'sd52) : (l_in - 14'sd51 - bn);
    end

    // shift to the rounding point, keep guard and sticky
    always_comb
    begin
        sm1     = s_reg - 7'd1;
        gv      = rp_reg >> sm1;
        lowmask = ~({PROD_W{1'b1}} << sm1);
    end

    // round to nearest even and pack; a carry steps into the exponent
    always_comb
    begin
        up  = g_reg & (st_reg | qv_reg[0]);
        qr  = qv_reg + {53'd0, up};
        enc = {1'b0, em1_reg, 52'd0} + {10'd0, qr};
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    state_next = sp_hit ? F_DONE : F_NORM;
                end
            end
            F_NORM:
            begin
                if (ma_reg[MANT_W-1] && mb_reg[MANT_W-1])
                begin
                    state_next = (op_reg == FOP_MUL) ? F_MUL : F_DIV;
                end
            end
            F_MUL:
            begin
                if (cnt_reg == 6'd4)
                begin
                    state_next = F_PREP;
                end
            end
            F_DIV:
            begin
                if (cnt_reg == 6'(DIV_STEPS - 1))
                begin
                    state_next = F_PREP;
                end
            end
            F_PREP:  state_next = F_SHIFT;
            F_SHIFT: state_next = F_ROUND;
            F_ROUND: state_next = F_DONE;
            F_DONE:  state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    op_reg   <= op;
                    sign_reg <= r_sign;
                    res_reg  <= sp_res;
                    ma_reg   <= {a_e != 11'd0, a_f};
                    mb_reg   <= {b_e != 11'd0, b_f};
                    ea_reg   <= (a_e == 11'd0) ? 14'sd1 : $signed({3'b000, a_e});
                    eb_reg   <= (b_e == 11'd0) ? 14'sd1 : $signed({3'b000, b_e});
                end
            end
            F_NORM:
            begin
                // subnormal mantissas move up eight or one place a cycle
                if (!ma_reg[MANT_W-1])
                begin
                    if (ma_reg[52:45] == 8'd0)
                    begin
                        ma_reg <= ma_reg << 8;
                        ea_reg <= ea_reg - 14'sd8;
                    end
                    else
                    begin
                        ma_reg <= ma_reg << 1;
                        ea_reg <= ea_reg - 14'sd1;
                    end
                end
                if (!mb_reg[MANT_W-1])
                begin
                    if (mb_reg[52:45] == 8'd0)
                    begin
                        mb_reg <= mb_reg << 8;
                        eb_reg <= eb_reg - 14'sd8;
                    end
                    else
                    begin
                        mb_reg <= mb_reg << 1;
                        eb_reg <= eb_reg - 14'sd1;
                    end
                end
                cnt_reg  <= 6'd0;
                prod_reg <= '0;
                q_reg    <= '0;
                rem_reg  <= {1'b0, ma_reg};
            end
            F_MUL:
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg != 6'd4)
                begin
                    pp_reg  <= pp;
                    psh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                end
                if (cnt_reg != 6'd0)
                begin
                    prod_reg <= prod_reg + pp_sh;
                end
            end
            F_DIV:
            begin
                cnt_reg <= cnt_reg + 6'd1;
                q_reg   <= {q_reg[QUO_W-2:0], ge};
                rem_reg <= {rem_sel[REM_W-2:0], 1'b0};
            end
            F_PREP:
            begin
                rp_reg   <= p_in;
                stin_reg <= stk_in;
                s_reg    <= (s_full > 14'sd107) ? 7'd107 : s_full[6:0];
                em1_reg  <= (bn >= 14'sd1) ? 11'(bn - 14'sd1) : 11'd0;
                ovf_reg  <= bn >= 14'sd2047;
            end
            F_SHIFT:
            begin
                qv_reg <= gv[54:1];
                g_reg  <= gv[0];
                st_reg <= (|(rp_reg & lowmask)) | stin_reg;
            end
            F_ROUND:
            begin
                res_reg <= ovf_reg ? {sign_reg, DBL_INF} : {sign_reg, enc[62:0]};
            end
            default:
            begin
            end
        endcase
    end

    assign done = state_reg == F_DONE;
    assign res  = res_reg;

endmodule

[rtl/core/fpbs_dp.sv]
// datapath: operand registers, table of squares, shared fp unit
// depends on fpbs_pkg, fpbs_ram, fpbs_fpu
module fpbs_dp #(
    parameter int EXP_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fpbs_pkg::ctrl_cmd_t        cmd,
    output fpbs_pkg::ctrl_stat_t       stat,
    input  logic [63:0]                base_bits,
    input  logic signed [EXP_WIDTH-1:0] exponent,
    output logic [63:0]                result_bits
);

    import fpbs_pkg::*;

    localparam int KW = $clog2(EXP_WIDTH);

    logic [63:0]          sq_reg;
    logic [63:0]          acc_reg;
    logic [63:0]          res_reg;
    logic [EXP_WIDTH-1:0] mag_reg;
    logic                 neg_reg;
    logic [KW-1:0]        k_reg;

    logic [EXP_WIDTH-1:0] mag_in;
    logic [63:0]          ram_rdata;
    logic [63:0]          fpu_a, fpu_b, fpu_res;
    fpu_op_t              fpu_op;
    logic                 fpu_done;

    // magnitude of the power; the most negative value fits unsigned
    assign mag_in = exponent[EXP_WIDTH-1] ? (~exponent + 1'b1) : exponent;

    // operand routing for the shared unit
    always_comb
    begin
        fpu_op = FOP_MUL;
        fpu_a  = sq_reg;
        fpu_b  = sq_reg;
        case (cmd.sel)
            SEL_ACC:
            begin
                fpu_a = acc_reg;
                fpu_b = ram_rdata;
            end
            SEL_RECIP:
            begin
                fpu_op = FOP_DIV;
                fpu_a  = DBL_ONE;
                fpu_b  = acc_reg;
            end
            default:
            begin
            end
        endcase
    end

    fpbs_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.fpu_start),
        .op    (fpu_op),
        .a     (fpu_a),
        .b     (fpu_b),
        .done  (fpu_done),
        .res   (fpu_res)
    );

    // squares base^(2^k), written going up, read going down
    fpbs_ram #(
        .WIDTH (64),
        .DEPTH (EXP_WIDTH)
    ) u_sq_ram (
        .clk   (clk),
        .we    (cmd.wr_sq),
        .waddr (k_reg),
        .wdata (sq_reg),
        .raddr (k_reg),
        .rdata (ram_rdata)
    );

    // bit index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else if (cmd.load)
        begin
            k_reg <= '0;
        end
        else if (cmd.take_sq)
        begin
            k_reg <= k_reg + 1'b1;
        end
        else if (cmd.k_dec)
        begin
            k_reg <= k_reg - 1'b1;
        end
    end

    // operand and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sq_reg  <= base_bits;
            mag_reg <= mag_in;
            neg_reg <= exponent[EXP_WIDTH-1];
        end
        else if (cmd.take_sq)
        begin
            sq_reg <= fpu_res;
        end
        if (cmd.acc_init)
        begin
            acc_reg <= DBL_ONE;
        end
        else if (cmd.take_acc)
        begin
            acc_reg <= fpu_res;
        end
        if (cmd.out_load)
        begin
            res_reg <= acc_reg;
        end
    end

    // status toward the controller
    always_comb
    begin
        stat.more_bits = ((mag_reg >> k_reg) >> 1) != '0;
        stat.bit_k     = mag_reg[k_reg];
        stat.k_zero    = k_reg == '0;
        stat.neg       = neg_reg;
        stat.fpu_done  = fpu_done;
    end

    assign result_bits = res_reg;

endmodule

[rtl/core/fpbs_ctrl.sv]
// controller: sequences squarings, accumulate multiplies and reciprocal
// depends on fpbs_pkg and the assertion macro header
`include "float_power_by_squaring_top_macros.svh"

module fpbs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  fpbs_pkg::ctrl_stat_t stat,
    output fpbs_pkg::ctrl_cmd_t  cmd
);

    import fpbs_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.sel    = SEL_SQ;
        unique case (state_reg)
            C_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = C_WR;
                end
            end
            C_WR:
            begin
                cmd.wr_sq  = 1'b1;
                state_next = C_CHK;
            end
            C_CHK:
            begin
                if (stat.more_bits)
                begin
                    cmd.fpu_start = 1'b1;
                    cmd.sel       = SEL_SQ;
                    state_next    = C_SQW;
                end
                else
                begin
                    cmd.acc_init = 1'b1;
                    state_next   = C_AK;
                end
            end
            C_SQW:
            begin
                if (stat.fpu_done)
                begin
                    cmd.take_sq = 1'b1;
                    state_next  = C_WR;
                end
            end
            C_AK:
            begin
                state_next = stat.bit_k ? C_ARD : C_ANX;
            end
            C_ARD:
            begin
                cmd.fpu_start = 1'b1;
                cmd.sel       = SEL_ACC;
                state_next    = C_AW;
            end
            C_AW:
            begin
                cmd.sel = SEL_ACC;
                if (stat.fpu_done)
                begin
                    cmd.take_acc = 1'b1;
                    state_next   = C_ANX;
                end
            end
            C_ANX:
            begin
                if (stat.k_zero)
                begin
                    state_next = stat.neg ? C_REC : C_OUT;
                end
                else
                begin
                    cmd.k_dec  = 1'b1;
                    state_next = C_AK;
                end
            end
            C_REC:
            begin
                cmd.fpu_start = 1'b1;
                cmd.sel       = SEL_RECIP;
                state_next    = C_RW;
            end
            C_RW:
            begin
                cmd.sel = SEL_RECIP;
                if (stat.fpu_done)
                begin
                    cmd.take_acc = 1'b1;
                    state_next   = C_OUT;
                end
            end
            C_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // output item valid
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    `FPBS_ASSERT_NOW(a_done_in_wait, stat.fpu_done, state_reg == C_SQW || state_reg == C_AW || state_reg == C_RW, "fp unit finished outside a wait state")
    `FPBS_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid_reg || out_ready, "result overwritten before taken")
    `FPBS_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == C_WR, "accepted item did not start")

endmodule

[rtl/core/float_power_by_squaring_top.sv]
// top level: binary64 base raised to a signed integer power
// depends on fpbs_pkg, fpbs_ctrl, fpbs_dp
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------
//  input    | in_valid / in_ready  | base_bits[63:0], exponent
//  output   | out_valid/ out_ready | result_bits[63:0]
//
// one item at a time; latency is set by the shared fp unit, which runs the
// squarings up to the highest set exponent bit, an accumulate multiply per
// set bit and the reciprocal of a negative power, plus normalisation of each
// subnormal operand
// asynchronous active-low reset; the next item is taken while a result waits
module float_power_by_squaring_top #(
    parameter int EXP_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [63:0]                 base_bits,
    input  logic signed [EXP_WIDTH-1:0] exponent,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [63:0]                 result_bits
);

    import fpbs_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // sequencer
    fpbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // arithmetic and storage
    fpbs_dp #(
        .EXP_WIDTH (EXP_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .base_bits   (base_bits),
        .exponent    (exponent),
        .result_bits (result_bits)
    );

endmodule

[test/tb_float_power_by_squaring_top.sv]
// testbench for float_power_by_squaring_top: binary64 base raised to an integer power
// depends on fpbs_pkg and float_power_by_squaring_top; predicts results with host reals
module tb_float_power_by_squaring_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fpbs_pkg::*;

    localparam int EW        = 32;
    localparam int CYC_LIMIT = 5000000;
    localparam int TAIL      = 1500;

    typedef struct {
        logic [63:0]          base;
        logic signed [EW-1:0] pwr;
        bit                   drain;
    } pow_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [63:0]          base_bits;
    logic signed [EW-1:0] exponent;
    logic                 out_valid;
    logic                 out_ready;
    logic [63:0]          result_bits;

    pow_item_t   pending_q[$];
    logic [63:0] power_q[$];
    int          n_errors = 0;
    int          cycle_cnt = 0;
    int          in_gap;
    int          out_gap;

    float_power_by_squaring_top #(.EXP_WIDTH(EW)) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .base_bits  (base_bits),
        .exponent   (exponent),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_bits(result_bits)
    );

    // expected encoding of base^pwr, squaring chain then high-to-low accumulate
    function automatic logic [63:0] pow_by_squaring(logic [63:0] base, logic [EW-1:0] pwr);
        real         sq[EW];
        real         acc;
        logic [EW-1:0] mag;
        logic [63:0] r;
        begin
            mag = pwr[EW-1] ? (~pwr + 1'b1) : pwr;
            if (mag == '0)
                return DBL_ONE;
            sq[0] = $bitstoreal(base);
            for (int k = 1; k < EW; k++)
                sq[k] = sq[k-1] * sq[k-1];
            acc = 1.0;
            for (int k = EW - 1; k >= 0; k--)
                if (mag[k])
                    acc = acc * sq[k];
            if (pwr[EW-1])
                acc = 1.0 / acc;
            r = $realtobits(acc);
            if (r[62:52] == 11'h7FF && r[51:0] != '0)
                r = DBL_QNAN;
            return r;
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        begin
            $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_cnt);
            n_errors++;
        end
    endtask

    task automatic add_item(logic [63:0] b, logic signed [EW-1:0] p, bit d = 0);
        pow_item_t it;
        begin
            it.base  = b;
            it.pwr   = p;
            it.drain = d;
            pending_q.push_back(it);
        end
    endtask

    // clock and cycle limit
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYC_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // driver: launch items from the pending queue after a random gap; drain items wait until the design is empty
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            base_bits <= '0;
            exponent  <= '0;
            in_gap    <= 0;
        end
        else
        begin
            pow_item_t it;
            bit        free;
            free = !in_valid || in_ready;
            if (free)
            begin
                if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain &&
                           (in_valid || power_q.size() > 0 || out_valid)))
                begin
                    it = pending_q.pop_front();
                    base_bits <= it.base;
                    exponent  <= it.pwr;
                    in_valid  <= 1'b1;
                    in_gap    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            logic [63:0] want;
            if (in_valid && in_ready)
                power_q.push_back(pow_by_squaring(base_bits, exponent));
            if (out_valid && out_ready)
            begin
                if (power_q.size() == 0)
                    report_mismatch("unexpected result", result_bits, '0);
                else
                begin
                    want = power_q.pop_front();
                    if (result_bits !== want)
                        report_mismatch("result_bits", result_bits, want);
                end
                out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                out_ready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap   <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // stimulus
    initial
    begin
        logic [63:0]          b;
        logic signed [EW-1:0] p;
        int                   mode;
        rst_n     = 1'b0;

        // special cases and extremes
        add_item(64'h7FF8_1234_0000_0001, 0);
        add_item(64'h4000_0000_0000_0000, 1);
        add_item(64'h4000_0000_0000_0000, -1);
        add_item(64'hBFF0_0000_0000_0000, 32'sh7FFF_FFFF);
        add_item(64'h3FF0_0000_0000_0001, 32'sh8000_0000);
        add_item(64'h0000_0000_0000_0000, 3);
        add_item(64'h8000_0000_0000_0000, 3);
        add_item(64'h8000_0000_0000_0000, 4);
        add_item(64'h8000_0000_0000_0000, -5);
        add_item(64'h0000_0000_0000_0000, -2);
        add_item(64'h7FF0_0000_0000_0000, -3);
        add_item(64'hFFF0_0000_0000_0000, 3);
        add_item(64'h0000_0000_0000_0001, 1);
        add_item(64'h0000_0000_0000_0001, -1);
        add_item(64'h000F_FFFF_FFFF_FFFF, 2);
        add_item(64'h7FEF_FFFF_FFFF_FFFF, 2);
        add_item(64'h3FE0_0000_0000_0000, 1100);
        add_item(64'h4000_0000_0000_0000, 1023);
        add_item(64'h4000_0000_0000_0000, 1024, 1);
        add_item(64'h4000_0000_0000_0000, -1074);
        add_item(64'hFFFF_FFFF_FFFF_FFFF, 7);
        add_item(64'h3FF0_0000_0000_0000, -32'sd2147483647);

        // random items, mostly bases near one and modest powers
        for (int i = 0; i < 450; i++)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 6)
                b = {1'($urandom), 11'($urandom_range(11'h3F0, 11'h40F)),
                     20'($urandom), 32'($urandom)};
            else if (mode < 8)
                b = {$urandom, $urandom};
            else
                b = {1'($urandom), 11'h000, 20'($urandom), 32'($urandom)};
            mode = $urandom_range(0, 9);
            if (mode < 6)
                p = $urandom_range(0, 200);
            else if (mode < 8)
                p = $urandom;
            else
                p = 32'sd1 <<< $urandom_range(0, 31);
            if ($urandom_range(0, 1))
                p = -p;
            add_item(b, p, (i % 150) == 75);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0);
        @(posedge clk);
        while (in_valid || power_q.size() > 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (n_errors == 0 && power_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
